// ===== design/sdlb_pkg.sv =====
// ----------------------------------------------------------------------------
// sdlb_pkg: shared types and constants for the separable low-band transform
// Command codes, the word types of both channels, and the link that runs
// along the row of multiply-accumulate cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sdlb_pkg;

    localparam int DEF_IN_SIDE  = 32;
    localparam int DEF_OUT_SIDE = 16;

    // Wide enough for any side from the supported range, up to 64.
    localparam int SIDE_W = 6;

    localparam logic [1:0] CMD_LOAD_ROW    = 2'd0;
    localparam logic [1:0] CMD_LOAD_COLUMN = 2'd1;
    localparam logic [1:0] CMD_LOAD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_READ_COEF   = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [9:0]         item_index;
        logic signed [15:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic [7:0]         coefficient_index;
    } t_out_item;

    // One operand word handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               pass2;
        logic               first;
        logic               last;
        logic [SIDE_W-1:0]  idx;
        logic [SIDE_W-1:0]  pos;
        logic signed [15:0] word;
    } t_link;

    // Basis load and coefficient read access, common to all cells.
    typedef struct packed {
        logic               row_we;
        logic [SIDE_W-1:0]  sel;
        logic [SIDE_W-1:0]  addr;
        logic signed [15:0] data;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== design/separable_dct_low_band.sv =====
// ----------------------------------------------------------------------------
// separable_dct_low_band: separable 2-D low-band transform, 32x32 to 16x16
// Loads bases and samples, runs R*X*C on a row of MAC cells, serves reads.
// ----------------------------------------------------------------------------
//  channel   | ports                   | handshake
//  ----------+-------------------------+----------------------------------
//  command   | start, busy, i_item     | taken when start is high, busy low
//  result    | o_valid, o_result       | one-cycle strobe, no back-pressure
//
// A load keeps busy high through the decode and execute states after acceptance,
// and a read through the read state as well, which registers its result word.
// The last sample starts the transform: after the decode and execute states
// come the first and the second pass, each followed by a drain state while
// the cell chain empties; each pass feeds one word per cycle into the chain.
// busy is high throughout.
// Reset is synchronous; stores hold no reset value and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_dct_low_band
    import sdlb_pkg::*;
#(
    parameter int IN_SIDE  = DEF_IN_SIDE,
    parameter int OUT_SIDE = DEF_OUT_SIDE
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_item,
    output logic          o_valid,
    output t_out_item     o_result
);

    localparam int SAMPLE_WORDS = IN_SIDE * IN_SIDE;
    localparam int BASIS_WORDS  = IN_SIDE * OUT_SIDE;
    localparam int COEF_WORDS   = OUT_SIDE * OUT_SIDE;
    localparam int SMP_AW  = $clog2(SAMPLE_WORDS);
    localparam int COL_AW  = $clog2(BASIS_WORDS);
    localparam int ADDR_W  = (SMP_AW > COL_AW) ? SMP_AW : COL_AW;
    localparam int CELL_W  = $clog2(OUT_SIDE);
    localparam int DRAIN   = OUT_SIDE + 6;
    localparam int DRN_W   = $clog2(DRAIN + 1);
    localparam logic [16:0] M_IN  = 17'(65536 / IN_SIDE);
    localparam logic [16:0] M_OUT = 17'(65536 / OUT_SIDE);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_PASS1  = 3'd4;
    localparam logic [2:0] S_DRAIN1 = 3'd5;
    localparam logic [2:0] S_PASS2  = 3'd6;
    localparam logic [2:0] S_DRAIN2 = 3'd7;

    logic signed [15:0] smp_mem [SAMPLE_WORDS];
    logic signed [15:0] col_mem [BASIS_WORDS];

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    t_in_item           r_cmd;
    logic [9:0]         r_q;
    logic [26:0]        q_prod;
    logic [16:0]        qd;
    logic [10:0]        rem;
    logic [9:0]         quot;
    logic [10:0]        div_d;
    logic [SIDE_W-1:0]  r_ca;
    logic [SIDE_W-1:0]  r_cb;
    logic [ADDR_W-1:0]  r_addr;
    logic [DRN_W-1:0]   r_drain;
    t_link              r_feed;
    t_link              n_feed;
    t_link              feed;
    logic signed [15:0] r_smp_rd;
    logic signed [15:0] r_col_rd;
    t_cell_cmd          cell_cmd;
    logic [CELL_W-1:0]  r_rd_sel;
    logic               r_rd_ok;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               exec_read;
    logic               idx_row_ok;
    logic               idx_col_ok;
    logic               idx_smp_ok;
    logic               idx_coef_ok;
    logic               last_sample;
    logic               inner_end;
    logic               outer_end;
    logic signed [31:0] rd_data [OUT_SIDE];
    t_link              link [OUT_SIDE];

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Index split by the side length: reciprocal product, one correction.
    assign div_d  = (r_cmd.command == CMD_READ_COEF) ? 11'(OUT_SIDE) : 11'(IN_SIDE);
    assign q_prod = 27'(r_cmd.item_index) *
                    27'((r_cmd.command == CMD_READ_COEF) ? M_OUT : M_IN);
    assign qd     = 17'(r_q) * 17'(div_d);

    always_comb begin
        rem  = 11'(r_cmd.item_index) - 11'(qd);
        quot = r_q;
        if (rem >= div_d) begin
            rem  = rem - div_d;
            quot = r_q + 10'd1;
        end
    end

    assign idx_row_ok  = 32'(r_cmd.item_index) < BASIS_WORDS;
    assign idx_col_ok  = 32'(r_cmd.item_index) < BASIS_WORDS;
    assign idx_smp_ok  = 32'(r_cmd.item_index) < SAMPLE_WORDS;
    assign idx_coef_ok = 32'(r_cmd.item_index) < COEF_WORDS;
    assign last_sample = 32'(r_cmd.item_index) == SAMPLE_WORDS - 1;
    assign exec_read   = (r_state == S_EXEC) && (r_cmd.command == CMD_READ_COEF);

    assign cell_cmd.row_we = (r_state == S_EXEC) && (r_cmd.command == CMD_LOAD_ROW)
                             && idx_row_ok;
    assign cell_cmd.sel    = SIDE_W'(quot);
    assign cell_cmd.addr   = SIDE_W'(rem);
    assign cell_cmd.data   = r_cmd.item_value;

    assign inner_end = (r_state == S_PASS1) ? (r_ca == SIDE_W'(IN_SIDE - 1))
                                            : (r_ca == SIDE_W'(IN_SIDE - 1));
    assign outer_end = (r_state == S_PASS1) ? (r_cb == SIDE_W'(IN_SIDE - 1))
                                            : (r_cb == SIDE_W'(OUT_SIDE - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_cmd.command == CMD_READ_COEF) begin
                    n_state = S_READ;
                end else if (r_cmd.command == CMD_LOAD_SAMPLE && last_sample) begin
                    n_state = S_PASS1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            S_PASS1: begin
                if (inner_end && outer_end) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: begin
                if (r_drain == DRN_W'(DRAIN)) begin
                    n_state = S_PASS2;
                end
            end
            S_PASS2: begin
                if (inner_end && outer_end) begin
                    n_state = S_DRAIN2;
                end
            end
            S_DRAIN2: begin
                if (r_drain == DRN_W'(DRAIN)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_feed       = '0;
        n_feed.valid = (r_state == S_PASS1) || (r_state == S_PASS2);
        n_feed.pass2 = (r_state == S_PASS2);
        n_feed.first = (r_ca == '0);
        n_feed.last  = inner_end;
        n_feed.idx   = r_ca;
        n_feed.pos   = r_cb;
        feed         = r_feed;
        feed.word    = r_feed.pass2 ? r_col_rd : r_smp_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_feed.valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_feed.valid <= n_feed.valid;
            r_out_valid  <= (r_state == S_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_cmd <= i_item;
        end
        r_q          <= q_prod[25:16];
        r_feed.pass2 <= n_feed.pass2;
        r_feed.first <= n_feed.first;
        r_feed.last  <= n_feed.last;
        r_feed.idx   <= n_feed.idx;
        r_feed.pos   <= n_feed.pos;
        r_feed.word  <= n_feed.word;
        if (exec_read) begin
            r_rd_sel <= CELL_W'(quot);
            r_rd_ok  <= idx_coef_ok;
        end
        if (r_state == S_READ) begin
            r_out.coefficient       <= r_rd_ok ? rd_data[r_rd_sel] : 32'sd0;
            r_out.coefficient_index <= r_cmd.item_index[7:0];
        end
        if (r_state == S_PASS1 || r_state == S_PASS2) begin
            if (inner_end) begin
                r_ca   <= '0;
                r_cb   <= r_cb + SIDE_W'(1);
                r_addr <= ADDR_W'(r_cb) + ADDR_W'(1);
            end else begin
                r_ca   <= r_ca + SIDE_W'(1);
                r_addr <= r_addr + ((r_state == S_PASS1) ? ADDR_W'(IN_SIDE)
                                                         : ADDR_W'(OUT_SIDE));
            end
            r_drain <= '0;
        end else if (r_state == S_DRAIN1 || r_state == S_DRAIN2) begin
            r_ca    <= '0;
            r_cb    <= '0;
            r_addr  <= '0;
            r_drain <= r_drain + DRN_W'(1);
        end else begin
            r_ca    <= '0;
            r_cb    <= '0;
            r_addr  <= '0;
            r_drain <= '0;
        end
    end

    // Central stores for samples and the column basis.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_cmd.command == CMD_LOAD_SAMPLE && idx_smp_ok) begin
            smp_mem[SMP_AW'(r_cmd.item_index)] <= r_cmd.item_value;
        end
        if (r_state == S_EXEC && r_cmd.command == CMD_LOAD_COLUMN && idx_col_ok) begin
            col_mem[COL_AW'(r_cmd.item_index)] <= r_cmd.item_value;
        end
        r_smp_rd <= smp_mem[SMP_AW'(r_addr)];
        r_col_rd <= col_mem[COL_AW'(r_addr)];
    end

    assign link[0] = feed;

    for (genvar g = 0; g < OUT_SIDE; g++) begin : g_cell
        if (g < OUT_SIDE - 1) begin : g_mid
            sdlb_cell #(
                .IN_SIDE  (IN_SIDE),
                .OUT_SIDE (OUT_SIDE),
                .CELL_ID  (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_link    (link[g]),
                .o_link    (link[g+1]),
                .i_cmd     (cell_cmd),
                .o_rd_data (rd_data[g])
            );
        end else begin : g_end
            sdlb_cell #(
                .IN_SIDE  (IN_SIDE),
                .OUT_SIDE (OUT_SIDE),
                .CELL_ID  (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_link    (link[g]),
                .o_link    (),
                .i_cmd     (cell_cmd),
                .o_rd_data (rd_data[g])
            );
        end
    end

endmodule

`default_nettype wire

// ===== design/sdlb_cell.sv =====
// ----------------------------------------------------------------------------
// sdlb_cell: one multiply-accumulate cell of the transform chain
// Holds one row of the row basis, one row of the partial block and one row
// of coefficients, and passes the streamed operand word to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module sdlb_cell
    import sdlb_pkg::*;
#(
    parameter int IN_SIDE  = DEF_IN_SIDE,
    parameter int OUT_SIDE = DEF_OUT_SIDE,
    parameter int CELL_ID  = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_link        i_link,
    output t_link             o_link,
    input  wire t_cell_cmd    i_cmd,
    output logic signed [31:0] o_rd_data
);

    localparam int ROW_AW  = $clog2(IN_SIDE);
    localparam int COEF_AW = $clog2(OUT_SIDE);
    localparam int ACC_W   = 40 + $clog2(IN_SIDE) + 1;

    localparam logic signed [ACC_W-1:0] P_MAX = ACC_W'(64'h7F_FFFF);
    localparam logic signed [ACC_W-1:0] P_MIN = -P_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] C_MAX = ACC_W'(64'h7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] C_MIN = -C_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(16384);

    logic signed [15:0] row_mem  [IN_SIDE];
    logic signed [23:0] part_mem [IN_SIDE];
    logic signed [31:0] coef_mem [OUT_SIDE];

    t_link              r_link;
    t_link              r_b;
    t_link              r_c;
    logic signed [15:0] r_loc_row;
    logic signed [23:0] r_loc_par;
    logic signed [39:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic               r_d_valid;
    logic               r_d_pass2;
    logic [SIDE_W-1:0]  r_d_pos;
    logic signed [ACC_W-1:0] r_d_sum;
    logic signed [23:0] loc;
    logic signed [ACC_W-1:0] rnd;
    logic signed [23:0] part_val;
    logic signed [31:0] coef_val;

    assign o_link = r_link;

    // Control flags of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
            r_b.valid    <= 1'b0;
            r_c.valid    <= 1'b0;
            r_d_valid    <= 1'b0;
        end else begin
            r_link.valid <= i_link.valid;
            r_b.valid    <= r_link.valid;
            r_c.valid    <= r_b.valid;
            r_d_valid    <= r_c.valid & r_c.last;
        end
    end

    // Operand path: neighbor word, local operand fetch, product, accumulate.
    always_ff @(posedge i_clk) begin
        r_link.pass2 <= i_link.pass2;
        r_link.first <= i_link.first;
        r_link.last  <= i_link.last;
        r_link.idx   <= i_link.idx;
        r_link.pos   <= i_link.pos;
        r_link.word  <= i_link.word;
        r_loc_row    <= row_mem[r_link.idx[ROW_AW-1:0]];
        r_loc_par    <= part_mem[r_link.idx[ROW_AW-1:0]];
        r_b.pass2    <= r_link.pass2;
        r_b.first    <= r_link.first;
        r_b.last     <= r_link.last;
        r_b.idx      <= r_link.idx;
        r_b.pos      <= r_link.pos;
        r_b.word     <= r_link.word;
        r_prod       <= loc * r_b.word;
        r_c.pass2    <= r_b.pass2;
        r_c.first    <= r_b.first;
        r_c.last     <= r_b.last;
        r_c.idx      <= r_b.idx;
        r_c.pos      <= r_b.pos;
        r_c.word     <= r_b.word;
        if (r_c.valid) begin
            r_acc <= n_acc;
        end
        r_d_pass2 <= r_c.pass2;
        r_d_pos   <= r_c.pos;
        r_d_sum   <= n_acc;
    end

    always_comb begin
        loc   = r_b.pass2 ? r_loc_par : 24'(r_loc_row);
        n_acc = (r_c.first ? '0 : r_acc) + ACC_W'(r_prod);
        rnd   = (r_d_sum + HALF) >>> 15;
        if (rnd > P_MAX) begin
            part_val = 24'(P_MAX);
        end else if (rnd < P_MIN) begin
            part_val = 24'(P_MIN);
        end else begin
            part_val = 24'(rnd);
        end
        if (rnd > C_MAX) begin
            coef_val = 32'(C_MAX);
        end else if (rnd < C_MIN) begin
            coef_val = 32'(C_MIN);
        end else begin
            coef_val = 32'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_we && i_cmd.sel == SIDE_W'(CELL_ID)) begin
            row_mem[i_cmd.addr[ROW_AW-1:0]] <= i_cmd.data;
        end
        if (r_d_valid && !r_d_pass2) begin
            part_mem[r_d_pos[ROW_AW-1:0]] <= part_val;
        end
        if (r_d_valid && r_d_pass2) begin
            coef_mem[r_d_pos[COEF_AW-1:0]] <= coef_val;
        end
        o_rd_data <= coef_mem[i_cmd.addr[COEF_AW-1:0]];
    end

endmodule

`default_nettype wire

// ===== design/sdlb_checker.sv =====
// ----------------------------------------------------------------------------
// sdlb_checker: port-level checks for the transform block
// Watches the command and result ports and the timing between them.
// ----------------------------------------------------------------------------
`default_nettype none

module sdlb_checker
    import sdlb_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire t_in_item  i_item,
    input wire logic      o_valid,
    input wire t_out_item o_result
);

    logic rd_acc;
    logic any_acc;

    assign any_acc = start && !busy;
    assign rd_acc  = any_acc && (i_item.command == CMD_READ_COEF);

    // Every accepted read is answered by a result word.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |-> ##4 o_valid) else $error("read gave no result word");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(rd_acc, 4)) else $error("result word without read");

    a_index_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.coefficient_index == $past(i_item.item_index[7:0], 4))
        else $error("echoed index differs from request");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_acc |=> busy) else $error("busy not raised after command");

endmodule

bind separable_dct_low_band sdlb_checker u_sdlb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

// ===== test/separable_dct_low_band_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// separable_dct_low_band_tb: self-checking bench for the low-band transform
// Fills both bases and the sample block, then triggers transforms. Every
// coefficient read is checked against a transform computed in the bench.
// Directed edge cases come first, then random traffic under three idle
// patterns on the command side.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_dct_low_band_tb;
    import sdlb_pkg::*;

    localparam int N_IN    = DEF_IN_SIDE;
    localparam int N_OUT   = DEF_OUT_SIDE;
    localparam int N_BASIS = N_IN * N_OUT;
    localparam int N_SAMP  = N_IN * N_IN;
    localparam int N_COEF  = N_OUT * N_OUT;
    localparam int STALL_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_valid;
    t_out_item o_result;

    separable_dct_low_band dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Bench copy of the block state.
    logic signed [15:0] row_ref   [N_BASIS];
    logic signed [15:0] col_ref   [N_BASIS];
    logic signed [15:0] samples   [N_SAMP];
    logic signed [31:0] coefs     [N_COEF];

    t_out_item pending_coefs[$];
    int        errors = 0;
    int        idle_pct = 0;
    int        stall_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint round_q15(input longint acc);
        return (acc + 64'sd16384) >>> 15;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Two-pass R*X*C with rounding and saturation after each pass.
    task automatic compute_low_band();
        logic signed [23:0] partial [N_BASIS];
        longint acc;
        for (int u = 0; u < N_OUT; u++) begin
            for (int x = 0; x < N_IN; x++) begin
                acc = 0;
                for (int y = 0; y < N_IN; y++)
                    acc += longint'(row_ref[u*N_IN+y]) * longint'(samples[y*N_IN+x]);
                partial[u*N_IN+x] = 24'(clamp(round_q15(acc), -(64'sd1 <<< 23),
                                              (64'sd1 <<< 23) - 1));
            end
        end
        for (int u = 0; u < N_OUT; u++) begin
            for (int k = 0; k < N_OUT; k++) begin
                acc = 0;
                for (int x = 0; x < N_IN; x++)
                    acc += longint'(partial[u*N_IN+x]) * longint'(col_ref[x*N_OUT+k]);
                coefs[u*N_OUT+k] = 32'(clamp(round_q15(acc), -(64'sd1 <<< 31),
                                             (64'sd1 <<< 31) - 1));
            end
        end
    endtask

    // Sends one word, holding start until the block takes it.
    task automatic send_word(input logic [1:0] cmd, input int idx, input logic [15:0] val);
        t_out_item exp_item;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_item.command    <= cmd;
        i_item.item_index <= idx[9:0];
        i_item.item_value <= val;
        start             <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
        case (cmd)
            CMD_LOAD_ROW:    if (idx < N_BASIS) row_ref[idx] = val;
            CMD_LOAD_COLUMN: if (idx < N_BASIS) col_ref[idx] = val;
            CMD_LOAD_SAMPLE: begin
                if (idx < N_SAMP) samples[idx] = val;
                if (idx == N_SAMP - 1) compute_low_band();
            end
            CMD_READ_COEF: begin
                exp_item.coefficient       = (idx < N_COEF) ? coefs[idx] : '0;
                exp_item.coefficient_index = idx[7:0];
                pending_coefs.push_back(exp_item);
            end
        endcase
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_coefs.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_fill_and_first_transform();
        for (int i = 0; i < N_BASIS; i++)
            send_word(CMD_LOAD_ROW, i, (i == 0) ? 16'h8000 : (i == 1) ? 16'h7fff : 16'($urandom));
        for (int i = 0; i < N_BASIS; i++)
            send_word(CMD_LOAD_COLUMN, i, (i == 0) ? 16'h7fff : 16'($urandom));
        for (int i = 0; i < N_SAMP; i++)
            send_word(CMD_LOAD_SAMPLE, i,
                      (i < 32) ? 16'h8000 : (i < 64) ? 16'h7fff : 16'($urandom));
    endtask

    task automatic test_edge_cases();
        // Loads beyond the basis stores are dropped.
        send_word(CMD_LOAD_ROW, N_BASIS, 16'h1234);
        send_word(CMD_LOAD_ROW, 1023, 16'hffff);
        send_word(CMD_LOAD_COLUMN, 700, 16'h8000);
        send_word(CMD_READ_COEF, 0, 16'hffff);
        send_word(CMD_READ_COEF, N_COEF - 1, 16'h0000);
        send_word(CMD_READ_COEF, 17, 16'h5555);
        // Reads past the coefficient block return zero with the index echoed.
        send_word(CMD_READ_COEF, N_COEF, 16'h0000);
        send_word(CMD_READ_COEF, 1023, 16'haaaa);
        send_word(CMD_READ_COEF, 512, 16'h0000);
        // Retrigger with the last sample at both extremes.
        send_word(CMD_LOAD_SAMPLE, N_SAMP - 1, 16'h8000);
        send_word(CMD_READ_COEF, 0, 16'h0000);
        send_word(CMD_READ_COEF, N_COEF - 1, 16'h0000);
        send_word(CMD_LOAD_SAMPLE, N_SAMP - 1, 16'h7fff);
        send_word(CMD_READ_COEF, 255, 16'h0000);
        send_word(CMD_READ_COEF, 128, 16'h0000);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int pct, input int count);
        int pick;
        int idx;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                idx = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(N_COEF - 1);
                send_word(CMD_READ_COEF, idx, 16'($urandom));
            end else if (pick < 52) begin
                send_word(CMD_LOAD_ROW, $urandom_range(1023), 16'($urandom));
            end else if (pick < 64) begin
                send_word(CMD_LOAD_COLUMN, $urandom_range(1023), 16'($urandom));
            end else if (pick < 67) begin
                send_word(CMD_LOAD_SAMPLE, N_SAMP - 1, 16'($urandom));
            end else begin
                send_word(CMD_LOAD_SAMPLE, $urandom_range(N_SAMP - 2), 16'($urandom));
            end
        end
        wait_drained();
    endtask

    // Result checker: every strobed word must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_coefs.size() == 0) begin
                $display("%0t: unexpected word: expected none actual %h", $time, o_result);
                errors++;
            end else begin
                if (o_result.coefficient !== pending_coefs[0].coefficient)
                    $display("%0t: coefficient mismatch: expected %0d actual %0d", $time,
                             pending_coefs[0].coefficient, o_result.coefficient);
                if (o_result.coefficient_index !== pending_coefs[0].coefficient_index)
                    $display("%0t: index mismatch: expected %0d actual %0d", $time,
                             pending_coefs[0].coefficient_index, o_result.coefficient_index);
                if (o_result !== pending_coefs[0]) errors++;
                void'(pending_coefs.pop_front());
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 0;
        test_fill_and_first_transform();
        test_edge_cases();
        test_random_traffic(31, 25);
        test_random_traffic(88, 25);
        test_random_traffic(0, 25);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_coefs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
